/* rtl/cfs_pkg.sv */
// cfs_pkg: widths, fixed-point constants and register indexes of the camera follow smoother
// no dependencies; imported by camera_follow_smoother

package cfs_pkg;

    localparam int ANGLE_BITS    = 12;
    localparam int FRACTION_BITS = 8;

    localparam int POS_W    = 24;
    localparam int ARM_W    = 22;
    localparam int SMOOTH_W = 7;
    localparam int THR_W    = 17;
    localparam int STR_W    = 7;
    localparam int ANGLE_W  = 12;
    localparam int LEVEL_W  = 15;
    localparam int OFS_W    = FRACTION_BITS + 9;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    localparam int MUL_W  = 26;
    localparam int PROD_W = 2 * MUL_W;
    localparam int D2_W   = 50;
    localparam int TH2_W  = 34;
    localparam int ST_W   = 24;
    localparam int DEN_W  = 41;
    localparam int NUM_W  = 64;
    localparam int NUM_IDX_W = $clog2(NUM_W);
    localparam int SIN_W  = 16;
    localparam int X_W    = 15;

    localparam int QB_GAIN  = 13;
    localparam int QB_SHAKE = FRACTION_BITS + 7;
    localparam int QUO_W    = (QB_SHAKE > QB_GAIN) ? QB_SHAKE : QB_GAIN;
    localparam int CNT_W    = $clog2(QUO_W + 1);

    localparam int GAIN_MAX   = 6554;
    localparam int GAIN_MIN   = 66;
    localparam int SMOOTH_MAX = 100;
    localparam int THR_MAX    = 128000;
    localparam int ARM_MIN    = 256;
    localparam int ARM_MAX    = 2560000;
    localparam int DECAY_MAX  = 100;
    localparam int STR_MAX    = 100;
    localparam int LEVEL_SCALE = 200;
    localparam int SHAKE_DIV  = 3276800;
    localparam int SHAKE_RND  = 1638400;
    // shake divisor is 25 * 2^17: shift, then reciprocal of 25
    localparam int SHAKE_SHIFT     = 17;
    localparam int SHAKE_RCP       = 1342178;
    localparam int SHAKE_RCP_SHIFT = 25;
    localparam int SIN_QUARTER = 16384;
    localparam int SIN_C1     = 1160;
    localparam int SIN_C2     = 10512;
    localparam int SIN_C3     = 25736;
    localparam int POS_MAX    = 8388607;
    localparam int POS_MIN    = -8388608;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOLLOW_SMOOTH = 4'd0,
        CFG_DIST_THRESH   = 4'd1,
        CFG_ARM_SMOOTH    = 4'd2,
        CFG_ARM_TARGET    = 4'd3,
        CFG_FRAME_LEFT    = 4'd4,
        CFG_FRAME_RIGHT   = 4'd5,
        CFG_FRAME_BOTTOM  = 4'd6,
        CFG_FRAME_TOP     = 4'd7
    } t_cfg_idx;

endpackage

/* rtl/camera_follow_smoother.sv */
// camera_follow_smoother: one frame tick of camera follow, arm smoothing and shake
// single module; depends on cfs_pkg
//
// usage
//   input channel: i_in_valid / o_in_stall carries one tick item (target, flags,
//   shake settings). output channel: o_out_valid / i_out_stall carries the view
//   after that tick. every accepted item gives exactly one result item.
//   configuration: i_cfg_we with i_cfg_idx and i_cfg_data, written while idle.
//   datapath: a full enabled tick is worked on by one shared 26x26 multiplier and a
//   one-bit-per-cycle restoring divider (13 steps per gain division, up to two
//   per item); each shake offset uses a reciprocal multiply on the shared
//   multiplier. a disabled item goes straight to the result state. one item is
//   worked on at a time; o_in_stall is high while it is in progress, so a new
//   item is taken only once the last one has moved to the output register.
//   the finished result sits in an output register, so the next item is
//   accepted while it waits; if the receiver stalls, a second result waits
//   in its last state until the register frees.
//   reset: synchronous, active low; clears configuration, view, arm and shake
//   state to their start values and drops o_out_valid.

module camera_follow_smoother (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [cfs_pkg::POS_W-1:0]      i_target_x,
    input  logic signed [cfs_pkg::POS_W-1:0]      i_target_y,
    input  logic                                  i_enabled,
    input  logic                                  i_restart,
    input  logic                                  i_start_shake,
    input  logic        [cfs_pkg::STR_W-1:0]      i_shake_strength,
    input  logic        [cfs_pkg::STR_W-1:0]      i_shake_decay,
    input  logic        [cfs_pkg::ANGLE_W-1:0]    i_shake_angle,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [cfs_pkg::POS_W-1:0]      o_view_x,
    output logic signed [cfs_pkg::POS_W-1:0]      o_view_y,
    output logic        [cfs_pkg::ARM_W-1:0]      o_view_arm_length,
    output logic                                  o_shaking,
    input  logic                                  i_cfg_we,
    input  logic        [cfs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic        [cfs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cfs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CLAMP, S_DIFF, S_DX2, S_DY2, S_TH1, S_TH2, S_TH3, S_CMP,
        S_N1, S_N2, S_DIVI, S_DIV, S_LX, S_LY, S_ARM, S_ARML, S_SHK,
        S_SIN0, S_SIN1, S_SIN2, S_SIN3, S_SIN4, S_OFF, S_RCP, S_OFS, S_APPLY, S_FIN
    } t_state;

    localparam int GAIN_W_T = 13;

    t_state r_state, r_ret;

    logic        [SMOOTH_W-1:0] r_fs, r_as;
    logic        [THR_W-1:0]    r_thr;
    logic        [ARM_W-1:0]    r_arm_tgt;
    logic signed [POS_W-1:0]    r_left, r_right, r_bottom, r_top;

    logic signed [POS_W-1:0]    r_view_x, r_view_y;
    logic        [ARM_W-1:0]    r_arm;
    logic                       r_active;
    logic        [LEVEL_W-1:0]  r_level;
    logic        [SMOOTH_W-1:0] r_step;
    logic signed [OFS_W-1:0]    r_last_x, r_last_y, r_ox;

    logic signed [POS_W-1:0]    r_tx, r_ty;
    logic        [ANGLE_W-1:0]  r_angle;
    logic signed [POS_W:0]      r_dx, r_dy;
    logic        [D2_W-1:0]     r_d2;
    logic        [ST_W-1:0]     r_st;
    logic        [TH2_W-1:0]    r_th2;
    logic        [DEN_W-1:0]    r_sth2;
    logic        [NUM_W-1:0]    r_num;
    logic        [DEN_W-1:0]    r_den, r_rem;
    logic        [QUO_W-1:0]    r_quo;
    logic        [CNT_W-1:0]    r_cnt;
    logic                       r_sel, r_neg;
    logic        [X_W-1:0]      r_x, r_x2;
    logic        [SIN_W-1:0]    r_t, r_s;

    logic                       r_o_valid;
    logic signed [POS_W-1:0]    r_o_x, r_o_y;
    logic        [ARM_W-1:0]    r_o_arm;
    logic                       r_o_shaking;

    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic        [GAIN_W_T-1:0] gain_c;

    logic signed [POS_W-1:0]    tx_cl, ty_cl;
    logic                       frame_on;
    logic        [NUM_IDX_W-1:0] bit_idx;
    logic        [DEN_W:0]      rem2;
    logic                       rem_ge;
    logic        [15:0]         phase;
    logic        [1:0]          quad;
    logic        [13:0]         frac;
    logic        [X_W-1:0]      x_c;
    logic signed [OFS_W-1:0]    ofs_c;
    logic        [SMOOTH_W-1:0] dec_c;
    logic        [STR_W-1:0]    str_c;
    logic                       fin_load;

    function automatic logic signed [POS_W:0] lerp_f(input logic signed [PROD_W-1:0] p,
                                                     input logic signed [POS_W:0] v);
        logic signed [PROD_W-1:0] rnd;
        logic signed [PROD_W-1:0] sum;
        rnd = p + 52'sd32768;
        sum = (rnd >>> 16) + PROD_W'(v);
        return sum[POS_W:0];
    endfunction

    function automatic logic signed [POS_W-1:0] sat_f(input logic signed [POS_W-1:0] v,
                                                      input logic signed [OFS_W-1:0] last,
                                                      input logic signed [OFS_W-1:0] o);
        logic signed [POS_W+1:0] s;
        s = (POS_W+2)'(v) - (POS_W+2)'(last) + (POS_W+2)'(o);
        if (s > (POS_W+2)'(POS_MAX)) begin
            return POS_W'(POS_MAX);
        end else if (s < (POS_W+2)'(POS_MIN)) begin
            return POS_W'(POS_MIN);
        end
        return s[POS_W-1:0];
    endfunction

    assign frame_on = (r_left != '0) && (r_right != '0) && (r_bottom != '0) && (r_top != '0);
    assign tx_cl = (r_tx < r_left) ? r_left : ((r_tx > r_right) ? r_right : r_tx);
    assign ty_cl = (r_ty < r_bottom) ? r_bottom : ((r_ty > r_top) ? r_top : r_ty);

    always_comb begin
        if (r_quo < QUO_W'(GAIN_MIN)) begin
            gain_c = GAIN_W_T'(GAIN_MIN);
        end else if (r_quo > QUO_W'(GAIN_MAX)) begin
            gain_c = GAIN_W_T'(GAIN_MAX);
        end else begin
            gain_c = r_quo[GAIN_W_T-1:0];
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_DX2:  begin mul_a = MUL_W'(r_dx); mul_b = MUL_W'(r_dx); end
            S_DY2:  begin mul_a = MUL_W'(r_dy); mul_b = MUL_W'(r_dy); end
            S_TH1:  begin mul_a = MUL_W'(r_fs); mul_b = MUL_W'(r_thr); end
            S_TH2:  begin mul_a = MUL_W'(r_thr); mul_b = MUL_W'(r_thr); end
            S_TH3:  begin mul_a = MUL_W'(r_st); mul_b = MUL_W'(r_thr); end
            S_N1:   begin mul_a = MUL_W'(r_d2[24:0]); mul_b = MUL_W'(GAIN_MAX); end
            S_N2:   begin mul_a = MUL_W'(r_d2[D2_W-1:25]); mul_b = MUL_W'(GAIN_MAX); end
            S_LX:   begin mul_a = MUL_W'(r_dx); mul_b = MUL_W'(gain_c); end
            S_LY:   begin mul_a = MUL_W'(r_dy); mul_b = MUL_W'(gain_c); end
            S_ARML: begin mul_a = MUL_W'(r_dx); mul_b = MUL_W'(gain_c); end
            S_SIN1: begin mul_a = MUL_W'(r_x); mul_b = MUL_W'(r_x); end
            S_SIN2: begin mul_a = MUL_W'(r_x2); mul_b = MUL_W'(SIN_C1); end
            S_SIN3: begin mul_a = MUL_W'(r_x2); mul_b = MUL_W'(r_t); end
            S_SIN4: begin mul_a = MUL_W'(r_x); mul_b = MUL_W'(r_t); end
            S_OFF:  begin mul_a = MUL_W'(r_level); mul_b = MUL_W'(r_s); end
            S_RCP:  begin mul_a = MUL_W'(r_num >> SHAKE_SHIFT); mul_b = MUL_W'(SHAKE_RCP); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign prod = mul_a * mul_b;

    assign bit_idx = NUM_IDX_W'(r_cnt) - NUM_IDX_W'(1);
    assign rem2    = {r_rem, r_num[bit_idx]};
    assign rem_ge  = rem2 >= {1'b0, r_den};

    assign phase = 16'(16'(r_angle[ANGLE_BITS-1:0]) << (16 - ANGLE_BITS));
    assign quad  = phase[15:14] + (r_sel ? 2'd0 : 2'd1);
    assign frac  = phase[13:0];
    assign x_c   = quad[0] ? X_W'(X_W'(SIN_QUARTER) - {1'b0, frac}) : {1'b0, frac};
    assign ofs_c = r_neg ? -OFS_W'(r_quo) : OFS_W'(r_quo);

    assign str_c = (i_shake_strength > STR_W'(STR_MAX)) ? STR_W'(STR_MAX) : i_shake_strength;
    assign dec_c = (i_shake_decay == '0) ? SMOOTH_W'(1) :
                   ((i_shake_decay > SMOOTH_W'(DECAY_MAX)) ? SMOOTH_W'(DECAY_MAX) : i_shake_decay);

    assign fin_load = (r_state == S_FIN) && (!r_o_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_fs        <= '0;
            r_as        <= '0;
            r_thr       <= '0;
            r_arm_tgt   <= ARM_W'(ARM_MIN);
            r_left      <= '0;
            r_right     <= '0;
            r_bottom    <= '0;
            r_top       <= '0;
            r_view_x    <= '0;
            r_view_y    <= '0;
            r_arm       <= ARM_W'(ARM_MIN);
            r_active    <= 1'b0;
            r_level     <= '0;
            r_step      <= SMOOTH_W'(1);
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_o_valid   <= 1'b0;
            r_sel       <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FOLLOW_SMOOTH: r_fs <= (i_cfg_data[6:0] > SMOOTH_W'(SMOOTH_MAX)) ?
                                               SMOOTH_W'(SMOOTH_MAX) : i_cfg_data[6:0];
                    CFG_DIST_THRESH:   r_thr <= (i_cfg_data[16:0] > THR_W'(THR_MAX)) ?
                                                THR_W'(THR_MAX) : i_cfg_data[16:0];
                    CFG_ARM_SMOOTH:    r_as <= (i_cfg_data[6:0] > SMOOTH_W'(SMOOTH_MAX)) ?
                                               SMOOTH_W'(SMOOTH_MAX) : i_cfg_data[6:0];
                    CFG_ARM_TARGET: begin
                        if (i_cfg_data[21:0] < ARM_W'(ARM_MIN)) begin
                            r_arm_tgt <= ARM_W'(ARM_MIN);
                        end else if (i_cfg_data[21:0] > ARM_W'(ARM_MAX)) begin
                            r_arm_tgt <= ARM_W'(ARM_MAX);
                        end else begin
                            r_arm_tgt <= i_cfg_data[21:0];
                        end
                    end
                    CFG_FRAME_LEFT:    r_left   <= i_cfg_data;
                    CFG_FRAME_RIGHT:   r_right  <= i_cfg_data;
                    CFG_FRAME_BOTTOM:  r_bottom <= i_cfg_data;
                    CFG_FRAME_TOP:     r_top    <= i_cfg_data;
                    default: ;
                endcase
            end

            if (fin_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_tx    <= i_target_x;
                        r_ty    <= i_target_y;
                        r_angle <= i_shake_angle;
                        if (i_enabled) begin
                            if (i_restart) begin
                                r_view_x <= i_target_x;
                                r_view_y <= i_target_y;
                                r_arm    <= r_arm_tgt;
                                r_last_x <= '0;
                                r_last_y <= '0;
                                if (!i_start_shake) begin
                                    r_active <= 1'b0;
                                    r_level  <= '0;
                                end
                            end
                            if (i_start_shake) begin
                                r_level  <= LEVEL_W'(str_c) * LEVEL_W'(LEVEL_SCALE);
                                r_step   <= dec_c;
                                r_active <= 1'b1;
                            end
                            r_state <= S_CLAMP;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_CLAMP: begin
                    if (frame_on) begin
                        r_tx <= tx_cl;
                        r_ty <= ty_cl;
                    end
                    if (r_fs == '0) begin
                        r_view_x <= frame_on ? tx_cl : r_tx;
                        r_view_y <= frame_on ? ty_cl : r_ty;
                        r_state  <= S_ARM;
                    end else begin
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_dx    <= (POS_W+1)'(r_tx) - (POS_W+1)'(r_view_x);
                    r_dy    <= (POS_W+1)'(r_ty) - (POS_W+1)'(r_view_y);
                    r_state <= S_DX2;
                end
                S_DX2: begin
                    r_d2    <= D2_W'(prod);
                    r_state <= S_DY2;
                end
                S_DY2: begin
                    r_d2 <= r_d2 + D2_W'(prod);
                    if (r_thr == '0) begin
                        r_quo   <= QUO_W'(GAIN_MAX);
                        r_state <= S_LX;
                    end else begin
                        r_state <= S_TH1;
                    end
                end
                S_TH1: begin
                    r_st    <= ST_W'(prod);
                    r_state <= S_TH2;
                end
                S_TH2: begin
                    r_th2   <= TH2_W'(prod);
                    r_state <= S_TH3;
                end
                S_TH3: begin
                    r_sth2  <= DEN_W'(prod);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_d2 <= D2_W'(r_th2)) begin
                        r_num   <= NUM_W'(GAIN_MAX);
                        r_den   <= DEN_W'(r_fs);
                        r_cnt   <= CNT_W'(QB_GAIN);
                        r_ret   <= S_LX;
                        r_state <= S_DIVI;
                    end else if (r_d2 >= D2_W'(r_sth2)) begin
                        r_quo   <= QUO_W'(GAIN_MAX);
                        r_state <= S_LX;
                    end else begin
                        r_state <= S_N1;
                    end
                end
                S_N1: begin
                    r_num   <= NUM_W'(prod);
                    r_state <= S_N2;
                end
                S_N2: begin
                    r_num   <= r_num + (NUM_W'(prod) << 25);
                    r_den   <= r_sth2;
                    r_cnt   <= CNT_W'(QB_GAIN);
                    r_ret   <= S_LX;
                    r_state <= S_DIVI;
                end
                S_DIVI: begin
                    r_rem   <= DEN_W'(r_num >> QB_GAIN);
                    r_quo   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= rem_ge ? DEN_W'(rem2 - {1'b0, r_den}) : rem2[DEN_W-1:0];
                    r_quo <= {r_quo[QUO_W-2:0], rem_ge};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= r_ret;
                    end
                end
                S_LX: begin
                    r_view_x <= POS_W'(lerp_f(prod, (POS_W+1)'(r_view_x)));
                    r_state  <= S_LY;
                end
                S_LY: begin
                    r_view_y <= POS_W'(lerp_f(prod, (POS_W+1)'(r_view_y)));
                    r_state  <= S_ARM;
                end
                S_ARM: begin
                    if (r_as == '0) begin
                        r_arm   <= r_arm_tgt;
                        r_state <= S_SHK;
                    end else begin
                        r_dx    <= (POS_W+1)'(r_arm_tgt) - (POS_W+1)'(r_arm);
                        r_num   <= NUM_W'(GAIN_MAX);
                        r_den   <= DEN_W'(r_as);
                        r_cnt   <= CNT_W'(QB_GAIN);
                        r_ret   <= S_ARML;
                        r_state <= S_DIVI;
                    end
                end
                S_ARML: begin
                    r_arm   <= ARM_W'(lerp_f(prod, (POS_W+1)'(r_arm)));
                    r_state <= S_SHK;
                end
                S_SHK: begin
                    if (!r_active) begin
                        r_state <= S_FIN;
                    end else if (r_level == '0) begin
                        r_active <= 1'b0;
                        r_state  <= S_FIN;
                    end else begin
                        r_sel   <= 1'b0;
                        r_state <= S_SIN0;
                    end
                end
                S_SIN0: begin
                    r_x     <= x_c;
                    r_neg   <= quad[1];
                    r_state <= S_SIN1;
                end
                S_SIN1: begin
                    r_x2    <= X_W'(prod >>> 14);
                    r_state <= S_SIN2;
                end
                S_SIN2: begin
                    r_t     <= SIN_W'(PROD_W'(SIN_C2) - (prod >>> 14));
                    r_state <= S_SIN3;
                end
                S_SIN3: begin
                    r_t     <= SIN_W'(PROD_W'(SIN_C3) - (prod >>> 14));
                    r_state <= S_SIN4;
                end
                S_SIN4: begin
                    r_s     <= SIN_W'(prod >>> 14);
                    r_state <= S_OFF;
                end
                S_OFF: begin
                    r_num   <= (NUM_W'(prod) << FRACTION_BITS) + NUM_W'(SHAKE_RND);
                    r_state <= S_RCP;
                end
                S_RCP: begin
                    r_quo   <= QUO_W'(prod >>> SHAKE_RCP_SHIFT);
                    r_state <= S_OFS;
                end
                S_OFS: begin
                    if (!r_sel) begin
                        r_ox    <= ofs_c;
                        r_sel   <= 1'b1;
                        r_state <= S_SIN0;
                    end else begin
                        r_view_x <= sat_f(r_view_x, r_last_x, r_ox);
                        r_view_y <= sat_f(r_view_y, r_last_y, ofs_c);
                        r_last_x <= r_ox;
                        r_last_y <= ofs_c;
                        r_state  <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    r_level <= (r_level > LEVEL_W'(r_step)) ? r_level - LEVEL_W'(r_step) : '0;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (fin_load) begin
                        r_o_x       <= r_view_x;
                        r_o_y       <= r_view_y;
                        r_o_arm     <= r_arm;
                        r_o_shaking <= r_active;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_o_valid;
    assign o_view_x          = r_o_x;
    assign o_view_y          = r_o_y;
    assign o_view_arm_length = r_o_arm;
    assign o_shaking         = r_o_shaking;

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// tb: self-checking bench for camera_follow_smoother, one tick item in and one view item out
// depends on cfs_pkg and camera_follow_smoother; holds its own tick predictor

module tb;
    import cfs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 4'd9;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE = 100;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int NUM_PHASES = 6;

    typedef struct {
        logic signed [POS_W-1:0] tx;
        logic signed [POS_W-1:0] ty;
        logic en, rs, sh;
        logic [STR_W-1:0] strength, decay;
        logic [ANGLE_W-1:0] angle;
        logic has_lit;
        logic signed [POS_W-1:0] lx, ly;
        logic [ARM_W-1:0] larm;
        logic lsh;
    } t_tick_row;

    typedef struct {
        logic signed [POS_W-1:0] x, y;
        logic [ARM_W-1:0] arm;
        logic shaking;
    } t_view;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic o_in_stall;
    logic signed [POS_W-1:0] tgt_x = '0, tgt_y = '0;
    logic en = 1'b0, rs = 1'b0, sh = 1'b0;
    logic [STR_W-1:0] strength = '0, decay = '0;
    logic [ANGLE_W-1:0] angle = '0;
    logic o_out_valid;
    logic out_stall = 1'b0;
    logic signed [POS_W-1:0] o_view_x, o_view_y;
    logic [ARM_W-1:0] o_view_arm_length;
    logic o_shaking;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    camera_follow_smoother dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(o_in_stall),
        .i_target_x(tgt_x), .i_target_y(tgt_y), .i_enabled(en), .i_restart(rs),
        .i_start_shake(sh), .i_shake_strength(strength), .i_shake_decay(decay),
        .i_shake_angle(angle),
        .o_out_valid(o_out_valid), .i_out_stall(out_stall),
        .o_view_x(o_view_x), .o_view_y(o_view_y),
        .o_view_arm_length(o_view_arm_length), .o_shaking(o_shaking),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predictor copy of configuration and state
    longint cf_follow, cf_thr, cf_arm_smooth, cf_arm_tgt;
    longint cf_left, cf_right, cf_bottom, cf_top;
    longint cam_x, cam_y, cam_arm, shk_level, shk_step, ofs_x, ofs_y;
    bit shk_on;

    t_view expected_views[$];
    int errors = 0;
    int send_idle = 0, recv_idle = 0;
    int ticks_sent = 0, views_seen = 0, quiet_cycles = 0;

    function automatic longint lerp(longint v, longint t, longint g);
        return v + (((t - v) * g + 32768) >>> 16);
    endfunction

    function automatic longint clamp_gain(longint g);
        return g < GAIN_MIN ? GAIN_MIN : (g > GAIN_MAX ? GAIN_MAX : g);
    endfunction

    function automatic longint sine_q14(int unsigned p);
        int unsigned q, r, x, x2, inner, mid;
        q = (p >> 14) & 3;
        r = p & 16383;
        x = (q & 1) ? 16384 - r : r;
        x2 = (x * x) >> 14;
        inner = 10512 - ((1160 * x2) >> 14);
        mid = 25736 - ((x2 * inner) >> 14);
        return (q & 2) ? -longint'((x * mid) >> 14) : longint'((x * mid) >> 14);
    endfunction

    function automatic longint shake_ofs(longint level, longint c);
        longint unsigned mag, o;
        mag = c < 0 ? -c : c;
        o = (longint'(level) * mag * (1 << FRACTION_BITS) + SHAKE_RND) / SHAKE_DIV;
        return c < 0 ? -longint'(o) : longint'(o);
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        longint v;
        case (idx)
            CFG_FOLLOW_SMOOTH: begin
                v = d & 'h7F; cf_follow = v > 100 ? 100 : v;
            end
            CFG_DIST_THRESH: begin
                v = d & 'h1FFFF; cf_thr = v > THR_MAX ? THR_MAX : v;
            end
            CFG_ARM_SMOOTH: begin
                v = d & 'h7F; cf_arm_smooth = v > 100 ? 100 : v;
            end
            CFG_ARM_TARGET: begin
                v = d & 'h3FFFFF;
                cf_arm_tgt = v < ARM_MIN ? ARM_MIN : (v > ARM_MAX ? ARM_MAX : v);
            end
            CFG_FRAME_LEFT: cf_left = longint'(signed'(d));
            CFG_FRAME_RIGHT: cf_right = longint'(signed'(d));
            CFG_FRAME_BOTTOM: cf_bottom = longint'(signed'(d));
            CFG_FRAME_TOP: cf_top = longint'(signed'(d));
            default: ;
        endcase
    endfunction

    function automatic t_view predict_tick(t_tick_row t);
        longint tx, ty, dx, dy, g, st, dc, c, sn, ox, oy;
        longint unsigned d2, th2;
        int unsigned p;
        t_view r;
        tx = t.tx;
        ty = t.ty;
        if (t.en) begin
            if (t.rs) begin
                cam_x = tx; cam_y = ty; cam_arm = cf_arm_tgt;
                shk_on = 0; shk_level = 0; ofs_x = 0; ofs_y = 0;
            end
            if (t.sh) begin
                st = t.strength > 100 ? 100 : t.strength;
                dc = t.decay < 1 ? 1 : (t.decay > 100 ? 100 : t.decay);
                shk_level = st * LEVEL_SCALE; shk_step = dc; shk_on = 1;
            end
            if (cf_left != 0 && cf_right != 0 && cf_bottom != 0 && cf_top != 0) begin
                tx = tx < cf_left ? cf_left : (tx > cf_right ? cf_right : tx);
                ty = ty < cf_bottom ? cf_bottom : (ty > cf_top ? cf_top : ty);
            end
            if (cf_follow != 0) begin
                dx = tx - cam_x; dy = ty - cam_y;
                d2 = dx * dx + dy * dy;
                if (cf_thr == 0) g = GAIN_MAX;
                else begin
                    th2 = cf_thr * cf_thr;
                    if (d2 <= th2) g = GAIN_MAX / cf_follow;
                    else if (d2 >= th2 * cf_follow) g = GAIN_MAX;
                    else g = (GAIN_MAX * d2) / (cf_follow * th2);
                end
                g = clamp_gain(g);
                cam_x = lerp(cam_x, tx, g);
                cam_y = lerp(cam_y, ty, g);
            end else begin
                cam_x = tx; cam_y = ty;
            end
            if (cf_arm_smooth != 0)
                cam_arm = lerp(cam_arm, cf_arm_tgt, clamp_gain(GAIN_MAX / cf_arm_smooth));
            else
                cam_arm = cf_arm_tgt;
            if (shk_on) begin
                if (shk_level == 0) shk_on = 0;
                else begin
                    p = (int'(t.angle) << (16 - ANGLE_BITS)) & 'hFFFF;
                    c = sine_q14((p + SIN_QUARTER) & 'hFFFF);
                    sn = sine_q14(p);
                    ox = shake_ofs(shk_level, c);
                    oy = shake_ofs(shk_level, sn);
                    cam_x = cam_x - ofs_x + ox;
                    cam_y = cam_y - ofs_y + oy;
                    cam_x = cam_x > POS_MAX ? POS_MAX : (cam_x < POS_MIN ? POS_MIN : cam_x);
                    cam_y = cam_y > POS_MAX ? POS_MAX : (cam_y < POS_MIN ? POS_MIN : cam_y);
                    ofs_x = ox; ofs_y = oy;
                    shk_level = shk_level > shk_step ? shk_level - shk_step : 0;
                end
            end
        end
        r.x = cam_x[POS_W-1:0];
        r.y = cam_y[POS_W-1:0];
        r.arm = cam_arm[ARM_W-1:0];
        r.shaking = shk_on;
        return r;
    endfunction

    task automatic send_tick(t_tick_row t);
        t_view v;
        if ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        tgt_x <= t.tx; tgt_y <= t.ty; en <= t.en; rs <= t.rs; sh <= t.sh;
        strength <= t.strength; decay <= t.decay; angle <= t.angle;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        v = predict_tick(t);
        if (t.has_lit) begin
            v.x = t.lx; v.y = t.ly; v.arm = t.larm; v.shaking = t.lsh;
        end
        expected_views.push_back(v);
        ticks_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_views.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= d;
        @(posedge i_clk);
        apply_reg(idx, d);
    endtask

    function automatic t_tick_row row(int tx, int ty, int e, int r, int s, int st, int dc,
                                      int a);
        t_tick_row t;
        t.tx = POS_W'(tx); t.ty = POS_W'(ty); t.en = e[0]; t.rs = r[0]; t.sh = s[0];
        t.strength = STR_W'(st); t.decay = STR_W'(dc); t.angle = ANGLE_W'(a);
        t.has_lit = 0; t.lx = 0; t.ly = 0; t.larm = 0; t.lsh = 0;
        return t;
    endfunction

    function automatic t_tick_row lit(t_tick_row t, int x, int y, int arm, int s);
        t.has_lit = 1; t.lx = POS_W'(x); t.ly = POS_W'(y); t.larm = ARM_W'(arm);
        t.lsh = s[0];
        return t;
    endfunction

    function automatic t_tick_row random_tick();
        t_tick_row t;
        int k;
        k = $urandom_range(99);
        t = row(0, 0, int'(k >= 6), int'($urandom_range(99) < 5),
                int'($urandom_range(99) < 12),
                $urandom_range(127), $urandom_range(127), $urandom_range(4095));
        if ($urandom_range(3) == 0) begin
            t.tx = POS_W'($urandom); t.ty = POS_W'($urandom);
        end else begin
            t.tx = POS_W'(cam_x + $signed($urandom_range(8191)) - 4096);
            t.ty = POS_W'(cam_y + $signed($urandom_range(8191)) - 4096);
        end
        return t;
    endfunction

    // receiver side and result check
    always @(posedge i_clk) begin
        t_view e;
        if (i_rst_n && o_out_valid && !out_stall) begin
            views_seen++;
            if (expected_views.size() == 0) begin
                $error("result with no tick waiting");
                errors++;
            end else begin
                e = expected_views.pop_front();
                if (o_view_x !== e.x) begin
                    $error("view_x expected %0d got %0d", e.x, o_view_x); errors++;
                end
                if (o_view_y !== e.y) begin
                    $error("view_y expected %0d got %0d", e.y, o_view_y); errors++;
                end
                if (o_view_arm_length !== e.arm) begin
                    $error("view_arm_length expected %0d got %0d", e.arm, o_view_arm_length);
                    errors++;
                end
                if (o_shaking !== e.shaking) begin
                    $error("shaking expected %0d got %0d", e.shaking, o_shaking); errors++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    t_tick_row directed[$];
    logic [CFG_DATA_W-1:0] phase_cfg[NUM_PHASES][8] = '{
        '{24'd127, 24'h1FFFF, 24'd127, 24'h3FFFFF, -24'sd256000, 24'd256000, -24'sd128000, 24'd128000},
        '{24'd1, 24'd1, 24'd1, 24'd0, 24'd5000, -24'sd5000, 24'd3000, -24'sd3000},
        '{24'd10, 24'd2560, 24'd5, 24'd50000, 24'd0, 24'd9000, -24'sd9000, 24'd9000},
        '{24'd0, 24'd0, 24'd0, 24'd300000, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF},
        '{24'd50, 24'd64000, 24'd100, 24'd2560000, 24'd256, 24'd25600, 24'd256, 24'd25600},
        '{24'd3, 24'd512, 24'd2, 24'd1000, 24'd0, 24'd0, 24'd0, 24'd0}
    };

    initial begin
        cf_follow = 0; cf_thr = 0; cf_arm_smooth = 0; cf_arm_tgt = ARM_MIN;
        cf_left = 0; cf_right = 0; cf_bottom = 0; cf_top = 0;
        cam_x = 0; cam_y = 0; cam_arm = ARM_MIN; shk_on = 0;
        shk_level = 0; shk_step = 1; ofs_x = 0; ofs_y = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: snap, no frame
        directed.push_back(lit(row(POS_MAX, POS_MIN, 1, 0, 0, 0, 0, 0),
                               POS_MAX, POS_MIN, ARM_MIN, 0));
        directed.push_back(lit(row(0, 0, 0, 1, 1, 100, 1, 0), POS_MAX, POS_MIN, ARM_MIN, 0));
        directed.push_back(lit(row(POS_MIN, POS_MAX, 1, 1, 0, 0, 0, 0),
                               POS_MIN, POS_MAX, ARM_MIN, 0));
        directed.push_back(lit(row(-1, 1, 1, 0, 0, 127, 127, 4095), -1, 1, ARM_MIN, 0));
        directed.push_back(row(POS_MAX, 0, 1, 0, 1, 127, 0, 0));
        directed.push_back(row(POS_MAX, 0, 1, 0, 0, 0, 0, 1024));
        directed.push_back(row(0, POS_MIN, 1, 0, 0, 0, 0, 2048));
        directed.push_back(row(0, POS_MIN, 1, 0, 0, 0, 0, 3072));
        directed.push_back(row(100, 100, 1, 0, 0, 0, 0, 4095));
        directed.push_back(row(100, 100, 1, 1, 1, 1, 100, 512));
        directed.push_back(row(100, 100, 1, 0, 0, 0, 0, 1536));
        directed.push_back(row(100, 100, 1, 0, 0, 0, 0, 2560));
        directed.push_back(row(100, 100, 1, 0, 0, 0, 0, 3584));
        directed.push_back(row(5, 5, 1, 0, 1, 0, 50, 0));
        directed.push_back(row(5, 5, 1, 0, 0, 0, 0, 0));
        directed.push_back(row(7, 7, 1, 0, 1, 60, 127, 700));
        directed.push_back(row(7, 7, 1, 1, 0, 0, 0, 0));
        directed.push_back(row(9, 9, 0, 0, 1, 100, 1, 0));
        foreach (directed[i]) send_tick(directed[i]);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            for (int r = 0; r < 8; r++) write_reg(CFG_IDX_W'(r), phase_cfg[ph][r]);
            write_reg(CFG_UNUSED_IDX, 24'hFFFFFF);
            cfg_we <= 1'b0;
            send_idle = ph < 2 ? 28 : (ph < 4 ? 62 : 0);
            recv_idle = ph < 2 ? 62 : (ph < 4 ? 28 : 0);
            send_tick(row($urandom, $urandom, 1, 1, 0, 0, 0, 0));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) send_tick(random_tick());
            drain();
        end

        $display("ticks sent %0d, views checked %0d, over %0d register settings",
                 ticks_sent, views_seen, NUM_PHASES + 1);
        $display("covered snap, gain curve, frame clamp, shake decay and saturation");
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
